// ----- rtl/core/vertex_position_dedup_table_top_assert.svh -----
// assertion macros for the vertex position dedup table
// no dependencies; expects clock and reset in the including module
`ifndef VERTEX_POSITION_DEDUP_TABLE_TOP_ASSERT_SVH
`define VERTEX_POSITION_DEDUP_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define VPDT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define VPDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VPDT_ASSERT_NOW(lbl, ante, cons, msg)
`define VPDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/vpdt_pkg.sv -----
// shared constants, types and helpers of the vertex position dedup table
// no dependencies
package vpdt_pkg;
   localparam int POSITION_DEPTH = 1024;
   localparam int TABLE_SLOTS    = 2048;
   localparam int STAMP_BITS     = 16;
   localparam int POS_BITS       = $clog2(POSITION_DEPTH);
   localparam int CNT_BITS       = POS_BITS + 1;
   localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
   localparam int SLOT_CNT_BITS  = SLOT_BITS + 1;
   localparam int OUT_POS_BITS   = 10;
   localparam int KEY_BITS       = 64;
   localparam int WORD_BITS      = 32;
   localparam int NUM_WORDS      = 6;
   localparam int WORDS_BITS     = WORD_BITS * NUM_WORDS;
   localparam int ROW_BITS       = KEY_BITS + POS_BITS + STAMP_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = QPTR_BITS + 1;
   localparam int MIX_SHIFT      = 33;
   localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam logic [31:0] ABS_MASK  = 32'h7fffffff;
   localparam logic [31:0] INF_BITS  = 32'h7f800000;

   typedef struct packed {
      logic                  mode;
      logic [KEY_BITS-1:0]   key;
      logic [WORDS_BITS-1:0] words;
      logic [SLOT_BITS-1:0]  idx;
   } vpdt_item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } vpdt_back_status_type;

   function automatic logic [63:0] mix_shift(input logic [63:0] k);
      return k ^ (k >> MIX_SHIFT);
   endfunction

   function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
      logic nan_a, nan_b;
      nan_a = (a & ABS_MASK) > INF_BITS;
      nan_b = (b & ABS_MASK) > INF_BITS;
      if (nan_a || nan_b) return 1'b0;
      if (((a | b) & ABS_MASK) == 32'h0) return 1'b1;
      return a == b;
   endfunction

   function automatic logic words_eq(input logic [WORDS_BITS-1:0] a,
                                     input logic [WORDS_BITS-1:0] b);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < NUM_WORDS; i++) begin
         eq = eq & fp_eq(a[i*WORD_BITS +: WORD_BITS], b[i*WORD_BITS +: WORD_BITS]);
      end
      return eq;
   endfunction
endpackage

// ----- rtl/core/vpdt_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module vpdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/core/vpdt_front.sv -----
// front end: takes request beats and hashes the nonzero identity of a lookup beat to a start slot
// depends on vpdt_pkg
module vpdt_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [63:0]                     req_vertex_key,
   input  logic [vpdt_pkg::WORDS_BITS-1:0] req_words,
   input  logic                            q_full,
   output logic                            q_push,
   output vpdt_pkg::vpdt_item_type         q_item
);
   import vpdt_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_HASH = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type     state_ff, state_in;
   logic                mode_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [WORDS_BITS-1:0] words_ff;
   logic [63:0]         k_ff, acc_ff, prod_ff;
   logic [1:0]          step_ff;
   logic                round_ff;
   logic [63:0]         mul_const, sum;
   logic [31:0]         op_a, op_c;

   assign req_stall = (state_ff != F_IDLE);
   assign q_push    = (state_ff == F_PUSH) && !q_full;
   assign q_item    = '{mode: mode_ff, key: key_ff, words: words_ff,
                        idx: k_ff[SLOT_BITS-1:0]};

   assign mul_const = round_ff ? MIX_MUL_B : MIX_MUL_A;
   assign sum       = acc_ff + {prod_ff[31:0], 32'h0};

   always_comb begin
      case (step_ff)
         2'd0:    begin op_a = k_ff[31:0];  op_c = mul_const[31:0];  end
         2'd1:    begin op_a = k_ff[63:32]; op_c = mul_const[31:0];  end
         default: begin op_a = k_ff[31:0];  op_c = mul_const[63:32]; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode || req_vertex_key == '0) ? F_PUSH : F_HASH;
            end
         end
         F_HASH: begin
            if (step_ff == 2'd3 && round_ff) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         mode_ff  <= req_mode;
         key_ff   <= req_vertex_key;
         words_ff <= req_words;
         k_ff     <= mix_shift(req_vertex_key);
         step_ff  <= 2'd0;
         round_ff <= 1'b0;
      end else if (state_ff == F_HASH) begin
         prod_ff <= 64'(op_a * op_c);
         step_ff <= step_ff + 2'd1;
         case (step_ff)
            2'd1: acc_ff <= prod_ff;
            2'd2: acc_ff <= sum;
            2'd3: begin
               k_ff     <= mix_shift(sum);
               round_ff <= 1'b1;
            end
            default: acc_ff <= acc_ff;
         endcase
      end
   end
endmodule

// ----- rtl/core/vpdt_queue.sv -----
// two entry queue between front and back end
// depends on vpdt_pkg
module vpdt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  vpdt_pkg::vpdt_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output vpdt_pkg::vpdt_item_type head_item
);
   import vpdt_pkg::*;

   vpdt_item_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] cnt_ff;

   assign full       = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end
endmodule

// ----- rtl/core/vpdt_back.sv -----
// back end: probes the slot table, appends positions, drives the response register
// depends on vpdt_pkg and vpdt_ram
module vpdt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  vpdt_pkg::vpdt_item_type           head_item,
   output vpdt_pkg::vpdt_back_status_type    status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vpdt_pkg::OUT_POS_BITS-1:0] rsp_slot_position,
   output logic                              rsp_reused,
   output logic                              rsp_key_conflict,
   output logic                              rsp_status
);
   import vpdt_pkg::*;

   typedef enum logic [3:0] {
      B_CLEAR = 4'b0001,
      B_IDLE  = 4'b0010,
      B_SLOT  = 4'b0100,
      B_WCMP  = 4'b1000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [STAMP_BITS-1:0]   stamp_ff, stamp_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [SLOT_BITS-1:0]    idx_ff, idx_in, clr_ff, clr_in;
   logic [SLOT_CNT_BITS-1:0] n_ff, n_in;
   logic                    conflict_ff, conflict_in;
   logic [POS_BITS-1:0]     target_ff, target_in;

   logic                    rsp_valid_ff;
   logic [OUT_POS_BITS-1:0] pos_ff;
   logic                    reused_ff, kc_ff, st_ff;

   logic                    emit, e_reused, e_kc, e_st;
   logic [POS_BITS-1:0]     e_pos;
   logic                    pop, out_free, store_full;
   logic [STAMP_BITS-1:0]   stamp_next;

   logic                    s_we;
   logic [SLOT_BITS-1:0]    s_waddr, s_raddr;
   logic [ROW_BITS-1:0]     s_wdata, s_rdata;
   logic [KEY_BITS-1:0]     row_key;
   logic [POS_BITS-1:0]     row_target;
   logic [STAMP_BITS-1:0]   row_stamp;
   logic                    w_we;
   logic [WORDS_BITS-1:0]   w_rdata;

   assign {row_key, row_target, row_stamp} = s_rdata;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign store_full = (count_ff == CNT_BITS'(POSITION_DEPTH));
   assign stamp_next = stamp_ff + 1'b1;
   assign s_raddr    = (state_ff == B_IDLE) ? head_item.idx : idx_ff + 1'b1;

   assign status = '{pop: pop, clearing: (state_ff == B_CLEAR)};

   vpdt_ram #(.WIDTH(ROW_BITS), .DEPTH(TABLE_SLOTS)) u_slot_ram (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(s_waddr),
      .wr_data(s_wdata),
      .rd_addr(s_raddr),
      .rd_data(s_rdata)
   );

   vpdt_ram #(.WIDTH(WORDS_BITS), .DEPTH(POSITION_DEPTH)) u_word_ram (
      .clock  (clock),
      .wr_en  (w_we),
      .wr_addr(count_ff[POS_BITS-1:0]),
      .wr_data(head_item.words),
      .rd_addr(row_target),
      .rd_data(w_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      stamp_in    = stamp_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      clr_in      = clr_ff;
      n_in        = n_ff;
      conflict_in = conflict_ff;
      target_in   = target_ff;
      emit        = 1'b0;
      e_pos       = '0;
      e_reused    = 1'b0;
      e_kc        = 1'b0;
      e_st        = 1'b0;
      pop         = 1'b0;
      s_we        = 1'b0;
      s_waddr     = idx_ff;
      s_wdata     = {head_item.key, count_ff[POS_BITS-1:0], stamp_ff};
      w_we        = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = clr_ff;
            s_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SLOT_BITS'(TABLE_SLOTS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (head_valid && out_free) begin
               if (head_item.mode) begin
                  pop      = 1'b1;
                  emit     = 1'b1;
                  count_in = '0;
                  stamp_in = stamp_next;
                  if (stamp_next == '0) begin
                     stamp_in = STAMP_BITS'(1);
                     clr_in   = '0;
                     state_in = B_CLEAR;
                  end
               end else if (head_item.key == '0) begin
                  pop  = 1'b1;
                  emit = 1'b1;
                  if (store_full) begin
                     e_st = 1'b1;
                  end else begin
                     w_we     = 1'b1;
                     e_pos    = count_ff[POS_BITS-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  idx_in      = head_item.idx;
                  n_in        = '0;
                  conflict_in = 1'b0;
                  state_in    = B_SLOT;
               end
            end
         end
         B_SLOT: begin
            if (row_stamp != stamp_ff) begin
               pop      = 1'b1;
               emit     = 1'b1;
               state_in = B_IDLE;
               if (store_full) begin
                  e_st = 1'b1;
               end else begin
                  s_we     = 1'b1;
                  w_we     = 1'b1;
                  e_pos    = count_ff[POS_BITS-1:0];
                  e_kc     = conflict_ff;
                  count_in = count_ff + 1'b1;
               end
            end else if (row_key == head_item.key) begin
               target_in = row_target;
               state_in  = B_WCMP;
            end else if (n_ff == SLOT_CNT_BITS'(TABLE_SLOTS - 1)) begin
               pop = 1'b1; emit = 1'b1; e_st = 1'b1; state_in = B_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               n_in   = n_ff + 1'b1;
            end
         end
         B_WCMP: begin
            if (words_eq(w_rdata, head_item.words)) begin
               pop      = 1'b1;
               emit     = 1'b1;
               e_pos    = target_ff;
               e_reused = 1'b1;
               state_in = B_IDLE;
            end else if (n_ff == SLOT_CNT_BITS'(TABLE_SLOTS - 1)) begin
               pop = 1'b1; emit = 1'b1; e_st = 1'b1; state_in = B_IDLE;
            end else begin
               conflict_in = 1'b1;
               idx_in      = idx_ff + 1'b1;
               n_in        = n_ff + 1'b1;
               state_in    = B_SLOT;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         stamp_ff     <= STAMP_BITS'(1);
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stamp_ff <= stamp_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      n_ff        <= n_in;
      conflict_ff <= conflict_in;
      target_ff   <= target_in;
      if (emit) begin
         pos_ff    <= OUT_POS_BITS'(e_pos);
         reused_ff <= e_reused;
         kc_ff     <= e_kc;
         st_ff     <= e_st;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_position = pos_ff;
   assign rsp_reused        = reused_ff;
   assign rsp_key_conflict  = kc_ff;
   assign rsp_status        = st_ff;
endmodule

// ----- rtl/core/vertex_position_dedup_table_top.sv -----
// top level of the vertex position dedup table
// depends on vpdt_pkg, vpdt_front, vpdt_queue, vpdt_back and the assertion header
`include "vertex_position_dedup_table_top_assert.svh"
// Per-frame vertex position dedup. Every request beat gives exactly one response beat,
// in order. A begin-frame beat restarts the position store and moves to a new
// generation; identity zero appends while the store has room; any other identity
// probes a linear-probing slot table (2048 slots) from its murmur-finalised hash.
// The front end hashes with a single 32x32 multiplier and holds one identity at a
// time: it takes no new beat until its item is pushed into the two-beat queue. The
// back end then reads one slot per cycle from the slot ram, plus a word compare
// state for each same-identity slot. After reset, and whenever the generation
// counter wraps, the back end sweeps all 2048 slots of the slot ram and takes no
// queued item; requests still enter the front end and the queue during that sweep.
module vertex_position_dedup_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [63:0] req_vertex_key,
   input  logic [31:0] req_view_x_bits,
   input  logic [31:0] req_view_y_bits,
   input  logic [31:0] req_view_z_bits,
   input  logic [31:0] req_proj_dist_bits,
   input  logic [31:0] req_center_x_bits,
   input  logic [31:0] req_center_y_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [vpdt_pkg::OUT_POS_BITS-1:0] rsp_slot_position,
   output logic        rsp_reused,
   output logic        rsp_key_conflict,
   output logic        rsp_status
);
   import vpdt_pkg::*;

   // position words, view x in the low lane
   logic [WORDS_BITS-1:0] req_words;
   assign req_words = {req_center_y_bits, req_center_x_bits, req_proj_dist_bits,
                       req_view_z_bits, req_view_y_bits, req_view_x_bits};

   // queue between the halves
   logic                 q_push, q_full, q_valid;
   vpdt_item_type        q_in, q_head;
   vpdt_back_status_type back_status;

   vpdt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_vertex_key(req_vertex_key),
      .req_words     (req_words),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_in)
   );

   vpdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .full      (q_full),
      .pop       (back_status.pop),
      .head_valid(q_valid),
      .head_item (q_head)
   );

   vpdt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_valid),
      .head_item        (q_head),
      .status           (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_position(rsp_slot_position),
      .rsp_reused       (rsp_reused),
      .rsp_key_conflict (rsp_key_conflict),
      .rsp_status       (rsp_status)
   );

   // back end only retires an item that is in the queue
   `VPDT_ASSERT_NOW(a_pop_has_item, back_status.pop, q_valid, "pop from empty queue")
   // nothing is pushed into a full queue
   `VPDT_ASSERT_NOW(a_no_overflow, q_push, !q_full, "push into full queue")
   // no item is retired while the slot sweep runs
   `VPDT_ASSERT_NOW(a_no_pop_in_sweep, back_status.clearing, !back_status.pop,
                    "item retired during slot sweep")
   // a retired item always leaves a response beat behind
   `VPDT_ASSERT_NEXT(a_pop_gives_beat, back_status.pop, rsp_valid, "retire without response")
endmodule

// ----- bench/vertex_position_dedup_table_checker.sv -----
// checker for the vertex position dedup table: watches both channels,
// predicts every response beat and compares it; depends on vpdt_pkg
`timescale 1ns / 1ps
module vertex_position_dedup_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_mode,
   input  logic [63:0] req_vertex_key,
   input  logic [31:0] req_view_x_bits,
   input  logic [31:0] req_view_y_bits,
   input  logic [31:0] req_view_z_bits,
   input  logic [31:0] req_proj_dist_bits,
   input  logic [31:0] req_center_x_bits,
   input  logic [31:0] req_center_y_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [vpdt_pkg::OUT_POS_BITS-1:0] rsp_slot_position,
   input  logic        rsp_reused,
   input  logic        rsp_key_conflict,
   input  logic        rsp_status,
   output int          fail_count,
   output int          pending_count
);
   import vpdt_pkg::*;

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] position;
      logic                    reused;
      logic                    conflict;
      logic                    status;
   } lookup_result_type;

   logic [63:0]           tbl_key   [TABLE_SLOTS];
   logic [POS_BITS-1:0]   tbl_pos   [TABLE_SLOTS];
   logic [STAMP_BITS-1:0] tbl_stamp [TABLE_SLOTS];
   logic [STAMP_BITS-1:0] generation;
   logic [31:0]           pos_words [POSITION_DEPTH][NUM_WORDS];
   int unsigned           pos_fill;
   lookup_result_type     awaited [$];

   function automatic logic [63:0] murmur_fin(input logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * 64'hff51afd7ed558ccd;
      k = k ^ (k >> 33);
      k = k * 64'hc4ceb9fe1a85ec53;
      return k ^ (k >> 33);
   endfunction

   function automatic logic float_same(input logic [31:0] a, input logic [31:0] b);
      if ((a & 32'h7fffffff) > 32'h7f800000 || (b & 32'h7fffffff) > 32'h7f800000)
         return 1'b0;
      if (((a | b) & 32'h7fffffff) == 0) return 1'b1;
      return a == b;
   endfunction

   function automatic lookup_result_type resolve(input logic mode, input logic [63:0] key,
                                                 input logic [31:0] w [NUM_WORDS]);
      lookup_result_type r;
      logic [SLOT_BITS-1:0] idx;
      logic conflict, free, same;
      r = '0;
      conflict = 0;
      free = 0;
      if (mode) begin
         pos_fill = 0;
         generation = generation + 1'b1;
         if (generation == 0) begin
            foreach (tbl_stamp[i]) tbl_stamp[i] = '0;
            generation = STAMP_BITS'(1);
         end
         return r;
      end
      if (key == 0) begin
         if (pos_fill >= POSITION_DEPTH) begin
            r.status = 1;
            return r;
         end
         for (int i = 0; i < NUM_WORDS; i++) pos_words[pos_fill][i] = w[i];
         r.position = OUT_POS_BITS'(pos_fill);
         pos_fill++;
         return r;
      end
      idx = SLOT_BITS'(murmur_fin(key));
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (tbl_stamp[idx] != generation) begin
            free = 1;
            break;
         end
         if (tbl_key[idx] == key) begin
            same = 1;
            for (int i = 0; i < NUM_WORDS; i++)
               same &= float_same(pos_words[tbl_pos[idx]][i], w[i]);
            if (same) begin
               r.position = tbl_pos[idx];
               r.reused = 1;
               return r;
            end
            conflict = 1;
         end
         idx = idx + 1'b1;
      end
      if (!free || pos_fill >= POSITION_DEPTH) begin
         r.status = 1;
         return r;
      end
      for (int i = 0; i < NUM_WORDS; i++) pos_words[pos_fill][i] = w[i];
      tbl_key[idx] = key;
      tbl_pos[idx] = POS_BITS'(pos_fill);
      tbl_stamp[idx] = generation;
      r.position = OUT_POS_BITS'(pos_fill);
      r.conflict = conflict;
      pos_fill++;
      return r;
   endfunction

   always @(posedge clock) begin
      logic [31:0] w [NUM_WORDS];
      lookup_result_type want;
      if (reset) begin
         foreach (tbl_stamp[i]) tbl_stamp[i] = '0;
         generation = STAMP_BITS'(1);
         pos_fill = 0;
         awaited.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response beat pos %0d", rsp_slot_position);
            end else begin
               want = awaited.pop_front();
               if (want != {rsp_slot_position, rsp_reused, rsp_key_conflict, rsp_status}) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: want pos %0d reu %b cfl %b st %b, got %0d %b %b %b",
                              want.position, want.reused, want.conflict, want.status,
                              rsp_slot_position, rsp_reused, rsp_key_conflict, rsp_status);
               end
            end
         end
         if (req_valid && !req_stall) begin
            w = '{req_view_x_bits, req_view_y_bits, req_view_z_bits,
                  req_proj_dist_bits, req_center_x_bits, req_center_y_bits};
            awaited.insert(awaited.size(), resolve(req_mode, req_vertex_key, w));
         end
      end
      pending_count = awaited.size();
   end
endmodule

// ----- bench/vertex_position_dedup_table_top_tb.sv -----
// stimulus and verdict for the vertex position dedup table
// depends on vpdt_pkg, the block and vertex_position_dedup_table_checker
`timescale 1ns / 1ps
module vertex_position_dedup_table_top_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_mode = 0;
   logic [63:0] req_vertex_key = 0;
   logic [31:0] req_view_x_bits = 0, req_view_y_bits = 0, req_view_z_bits = 0;
   logic [31:0] req_proj_dist_bits = 0, req_center_x_bits = 0, req_center_y_bits = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [vpdt_pkg::OUT_POS_BITS-1:0] rsp_slot_position;
   logic        rsp_reused, rsp_key_conflict, rsp_status;
   int          fail_count, pending_count;
   bit          long_hold = 0;    // asks the receiver for one long hold-off

   // small pools so identities repeat and positions get shared
   logic [63:0] key_pool  [16];
   logic [31:0] word_pool [8];

   always #5 clock = ~clock;

   vertex_position_dedup_table_top DUT (.*);
   vertex_position_dedup_table_checker checker_i (.*);

   // receiver stall pattern: runs of free and stalled cycles, with one long hold
   initial begin
      int mode_sel, run;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else begin
            mode_sel = $urandom_range(0, 3);
            run = $urandom_range(1, 20);
            rsp_stall <= (mode_sel == 0) ? 0 : ($urandom_range(0, 3) == 0);
            repeat (run - 1) begin
               @(negedge clock);
               if (mode_sel != 0 && !long_hold) rsp_stall <= ($urandom_range(0, 3) == 0);
            end
         end
      end
   end

   // one beat: drive at the falling edge, hold until accepted
   task automatic send_beat(input logic mode, input logic [63:0] key, input logic [31:0] w [6]);
      req_valid <= 1;
      req_mode <= mode;
      req_vertex_key <= key;
      req_view_x_bits <= w[0];
      req_view_y_bits <= w[1];
      req_view_z_bits <= w[2];
      req_proj_dist_bits <= w[3];
      req_center_x_bits <= w[4];
      req_center_y_bits <= w[5];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;   // negative zero
         2: return 32'h7fc0_0001;   // nan
         3: return $urandom();
         default: return word_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   initial begin
      logic [31:0] w [6];
      logic [63:0] k;
      int gap;
      foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
      foreach (word_pool[i]) word_pool[i] = $urandom();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, both zeros, nan, conflict, begin frame
      w = '{default: 32'h0};
      send_beat(0, 64'h0, w);
      send_beat(0, 64'hffff_ffff_ffff_ffff, w);
      w = '{default: 32'h8000_0000};
      send_beat(0, 64'hffff_ffff_ffff_ffff, w);      // reuse across signed zeros
      w = '{default: 32'hffff_ffff};
      send_beat(0, 64'hffff_ffff_ffff_ffff, w);      // conflict
      send_beat(0, 64'hffff_ffff_ffff_ffff, w);      // nan never matches
      w = '{default: 32'h3f80_0000};
      send_beat(0, 64'h1, w);
      send_beat(0, 64'h1, w);                        // plain reuse
      send_beat(1, 64'h1, w);                        // new frame
      send_beat(0, 64'h1, w);
      // fill the store to reach the full status, then begin frame
      for (int i = 0; i < 1030; i++) begin
         k = (i % 3 == 0) ? 64'h0 : {$urandom(), $urandom()};
         w = '{default: $urandom()};
         send_beat(0, k, w);
      end
      send_beat(0, 64'h1, w);
      send_beat(1, 64'h0, w);

      // pause until every response has come
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);

      // random part in bursts
      for (int n = 0; n < 200; n++) begin
         if (n == 100) long_hold = 1;
         if ($urandom_range(0, 15) == 0) begin
            req_valid <= 0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: k = 64'h0;
            1: k = {$urandom(), $urandom()};
            default: k = key_pool[$urandom_range(0, 15)];
         endcase
         foreach (w[i]) w[i] = pick_word();
         send_beat($urandom_range(0, 99) == 0, k, w);
      end
      req_valid <= 0;

      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("vertex_position_dedup_table_top_tb passed");
      else
         $display("vertex_position_dedup_table_top_tb failed");
      $finish;
   end

   // timeout well beyond the slowest legal run
   initial begin
      #5ms;
      $display("vertex_position_dedup_table_top_tb failed");
      $finish;
   end
endmodule

// ----- vertex_position_dedup_table_top.f -----
+incdir+rtl/core
rtl/core/vpdt_pkg.sv
rtl/core/vpdt_ram.sv
rtl/core/vpdt_front.sv
rtl/core/vpdt_queue.sv
rtl/core/vpdt_back.sv
rtl/core/vertex_position_dedup_table_top.sv
bench/vertex_position_dedup_table_checker.sv
bench/vertex_position_dedup_table_top_tb.sv
